/* hdl/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine: transaction
// payloads, action codes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ole_pkg;

   localparam int ACTION_W = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Action codes carried by a request transaction.
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_REMOVE     = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_FIND       = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_COUNT      = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_DUMP       = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd8;

   // Status codes carried by a response transaction.
   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STS_FULL     = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] value;
   } ole_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        position;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] element;
      logic                      last;
   } ole_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DUMP
   } ole_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK,
      OP_REMOVE_MATCH,
      OP_CLEAR,
      OP_ROTATE
   } ole_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;
      ole_op_type          op;
      logic                emit;
      logic [STATUS_W-1:0] status;
      logic                use_position;
      logic                use_element;
      logic                last;
   } ole_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic               empty;
      logic               full;
      logic               found;
      logic [COUNT_W-1:0] length;
   } ole_sts_type;

endpackage

/* hdl/ole_ctrl.sv */
// ----------------------------------------------------------------------------
// ole_ctrl
// Controller for the ordered list engine: accepts a request, decodes the
// action and sequences the datapath, including the element-by-element dump.
// ----------------------------------------------------------------------------
module ole_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ole_pkg::ACTION_W-1:0]         req_action,
   input  ole_pkg::ole_sts_type                 sts,
   output ole_pkg::ole_cmd_type                 cmd,
   output logic                                 busy
);
   import ole_pkg::*;

   ole_state_type       state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [COUNT_W-1:0]  dump_cnt_ff, dump_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         action_ff   <= ACT_COUNT;
         dump_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         action_ff   <= action_in;
         dump_cnt_ff <= dump_cnt_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      action_in        = action_ff;
      dump_cnt_in      = dump_cnt_ff;
      cmd              = '0;
      cmd.op           = OP_NONE;
      cmd.status       = STS_OK;
      busy             = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               action_in   = req_action;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            state_in = ST_IDLE;
            case (action_ff)
               ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.status = STS_FULL;
                  end else begin
                     cmd.op = (action_ff == ACT_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_BACK;
                  end
               end
               ACT_POP_FRONT, ACT_POP_BACK: begin
                  if (sts.empty) begin
                     cmd.status = STS_EMPTY;
                  end else begin
                     cmd.op = (action_ff == ACT_POP_FRONT) ? OP_POP_FRONT : OP_POP_BACK;
                  end
               end
               ACT_REMOVE, ACT_FIND: begin
                  if (sts.empty) begin
                     cmd.status = STS_EMPTY;
                  end else if (!sts.found) begin
                     cmd.status = STS_NOTFOUND;
                  end else if (action_ff == ACT_REMOVE) begin
                     cmd.op = OP_REMOVE_MATCH;
                  end else begin
                     cmd.use_position = 1'b1;
                  end
               end
               ACT_DUMP: begin
                  if (sts.empty) begin
                     cmd.status = STS_EMPTY;
                  end else begin
                     // First element goes out now; the list rotates so the
                     // next element lands in the front cell.
                     cmd.op          = OP_ROTATE;
                     cmd.use_element = 1'b1;
                     cmd.last        = (sts.length == COUNT_W'(1));
                     dump_cnt_in     = COUNT_W'(1);
                     if (sts.length != COUNT_W'(1)) begin
                        state_in = ST_DUMP;
                     end
                  end
               end
               ACT_CLEAR: begin
                  cmd.op = OP_CLEAR;
               end
               default: begin
                  // Count and undefined codes report the current length.
               end
            endcase
         end

         ST_DUMP: begin
            cmd.emit        = 1'b1;
            cmd.op          = OP_ROTATE;
            cmd.use_element = 1'b1;
            cmd.last        = (dump_cnt_ff == sts.length - COUNT_W'(1));
            dump_cnt_in     = dump_cnt_ff + COUNT_W'(1);
            if (cmd.last) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/ole_datapath.sv */
// ----------------------------------------------------------------------------
// ole_datapath
// Shift-register list of cells with a parallel compare row, first-match
// encoder, length register and the registered response stage.
// ----------------------------------------------------------------------------
module ole_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ole_pkg::ole_req_type req_payload,
   input  ole_pkg::ole_cmd_type cmd,
   output ole_pkg::ole_sts_type sts,
   output ole_pkg::ole_rsp_type rsp_payload,
   output logic                 rsp_strobe
);
   import ole_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic signed [VALUE_W-1:0] cells_ff [CAPACITY];
   logic signed [VALUE_W-1:0] cells_in [CAPACITY];
   logic [CAPACITY-1:0]       match_ff, match_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0]        length_ff, length_in;
   ole_rsp_type               rsp_ff, rsp_in;
   logic                      rsp_strobe_ff;
   logic [IDX_W-1:0]          first_idx;
   logic [IDX_W-1:0]          shift_from;
   logic [COUNT_W-1:0]        len_m1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         length_ff     <= length_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      match_ff <= match_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

   // Compare row: every live cell is checked against the request value as
   // the transaction is taken.
   always_comb begin
      match_in = match_ff;
      value_in = value_ff;
      if (cmd.capture) begin
         value_in = req_payload.value;
         for (int i = 0; i < CAPACITY; i++) begin
            match_in[i] = (cells_ff[i] == req_payload.value) && (COUNT_W'(i) < length_ff);
         end
      end
   end

   // First match, lowest index wins.
   always_comb begin
      first_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            first_idx = IDX_W'(i);
         end
      end
   end

   assign sts.empty  = (length_ff == '0);
   assign sts.full   = (length_ff == COUNT_W'(CAPACITY));
   assign sts.found  = |match_ff;
   assign sts.length = length_ff;

   assign len_m1     = length_ff - COUNT_W'(1);
   assign shift_from = (cmd.op == OP_REMOVE_MATCH) ? first_idx : '0;

   // Cell updates and length.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end
      length_in = length_ff;

      case (cmd.op)
         OP_PUSH_FRONT: begin
            cells_in[0] = value_ff;
            for (int i = 1; i < CAPACITY; i++) begin
               cells_in[i] = cells_ff[i-1];
            end
            length_in = length_ff + COUNT_W'(1);
         end
         OP_PUSH_BACK: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if (COUNT_W'(i) == length_ff) begin
                  cells_in[i] = value_ff;
               end
            end
            length_in = length_ff + COUNT_W'(1);
         end
         OP_POP_FRONT, OP_REMOVE_MATCH: begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
               if (IDX_W'(i) >= shift_from) begin
                  cells_in[i] = cells_ff[i+1];
               end
            end
            length_in = len_m1;
         end
         OP_POP_BACK: begin
            length_in = len_m1;
         end
         OP_CLEAR: begin
            length_in = '0;
         end
         OP_ROTATE: begin
            // Rotate the live part of the list by one toward the front.
            for (int i = 0; i < CAPACITY - 1; i++) begin
               if (COUNT_W'(i) == len_m1) begin
                  cells_in[i] = cells_ff[0];
               end else if (COUNT_W'(i) < len_m1) begin
                  cells_in[i] = cells_ff[i+1];
               end
            end
            if (len_m1 == COUNT_W'(CAPACITY - 1)) begin
               cells_in[CAPACITY-1] = cells_ff[0];
            end
         end
         default: begin
         end
      endcase
   end

   // Response stage.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit) begin
         rsp_in.status   = cmd.status;
         rsp_in.position = cmd.use_position ? COUNT_W'(first_idx) + COUNT_W'(1) : '0;
         rsp_in.count    = length_in;
         rsp_in.element  = cmd.use_element ? cells_ff[0] : '0;
         rsp_in.last     = cmd.last;
      end
   end

   assign rsp_payload = rsp_ff;
   assign rsp_strobe  = rsp_strobe_ff;

endmodule

/* hdl/ordered_list_engine_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Ordered list of up to CAPACITY signed words with push, pop, remove, find,
// count, dump and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (action and value in req_payload) is taken at a
//   rising edge where start is high and busy is low. Each response
//   transaction appears on rsp_payload for exactly one cycle, flagged by
//   rsp_strobe; the receiver cannot stall it, so responses never wait.
//   The last flag marks the final response of a command.
// Sequencing:
//   The compare row checks every cell against the value in the cycle the
//   request is taken, and the command executes in the following cycle.
//   The response register and its strobe are loaded at the end of the
//   execute cycle. For commands other than a dump, busy is high for that
//   one execute cycle only, so no new request is taken before it ends;
//   the response register lets the next request be taken while the
//   previous response is on the ports. A dump of L elements (L at least
//   one) streams one element per cycle, front first, by rotating the list
//   through the front cell, and busy stays high until the last element
//   has been loaded into the response register.
// Reset:
//   Reset empties the list and drops any pending response. The cells
//   themselves are not cleared; only cells below the length are read.
// ----------------------------------------------------------------------------
module ordered_list_engine_core #(
   parameter int CAPACITY = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ole_pkg::ole_req_type req_payload,
   output logic                 rsp_strobe,
   output ole_pkg::ole_rsp_type rsp_payload
);
   import ole_pkg::*;

   // Command and status bundles between the controller and the datapath.
   ole_cmd_type cmd;
   ole_sts_type sts;

   // The controller owns the state machine, the decoded action and the
   // dump sequence counter.
   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_payload.action),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   // The datapath owns the cells, the match vector, the length and the
   // response register.
   ole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload),
      .rsp_strobe  (rsp_strobe)
   );

endmodule
